[hw/rtl/wke_pkg.sv]
// ----------------------------------------------------------------------------
// wke_pkg
// Shared constants for the wave kernel term evaluator: register map,
// kernel kind codes, field widths and register reset values.
// ----------------------------------------------------------------------------
package wke_pkg;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANSATZ_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_TYPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_H      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_INDEX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FOUR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_TWO   = 3'd5;

    // Kernel kinds
    typedef enum logic [1:0] {
        ANSATZ_PLAIN  = 2'd0,
        ANSATZ_CONST  = 2'd1,
        ANSATZ_LINEAR = 2'd2,
        ANSATZ_NONE   = 2'd3
    } t_ansatz;

    // Field widths fixed by the interface
    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIST_W  = 33;
    localparam int unsigned NUM_W   = 48;
    localparam int unsigned DELAY_W = 10;
    localparam int unsigned TERM_W  = 3;

    // Register reset values
    localparam logic [31:0] RST_STEP_H     = 32'd65536;
    localparam logic [31:0] RST_SCALE_FOUR = 32'd85445659;
    localparam logic [31:0] RST_SCALE_TWO  = 32'd170891318;

endpackage

[hw/rtl/wave_kernel_term_eval_top.sv]
// Throughput: one transaction per cycle while the output is not stalled; the 33-step square root and the
// (FRAC_BITS + 33)-step restoring divider are each fully pipelined, one step per stage.
// A stalled output freezes the whole pipeline; no transaction is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// wave_kernel_term_eval_top
// Distance of two 3-D points and the numerator of one term of the
// time-convolved wave kernel (plain, piecewise constant, piecewise linear).
// ----------------------------------------------------------------------------
module wave_kernel_term_eval_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [31:0]   i_x_coord_0,
    input  logic signed [31:0]   i_x_coord_1,
    input  logic signed [31:0]   i_x_coord_2,
    input  logic signed [31:0]   i_y_coord_0,
    input  logic signed [31:0]   i_y_coord_1,
    input  logic signed [31:0]   i_y_coord_2,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [32:0]          o_distance,
    output logic signed [47:0]   o_numerator,
    output logic                 o_valid_res,
    output logic                 o_clipped
);

    localparam int unsigned SQ_N = 33;               // square root steps
    localparam int unsigned DW   = 33 + FRAC_BITS;   // dividend / quotient bits
    localparam int unsigned RW   = DW + 1;           // rho before saturation
    localparam int unsigned PW   = 98;               // 64 x 34 product
    localparam int unsigned SH_I = 2 * FRAC_BITS;
    localparam int unsigned SH_O = 2 * FRAC_BITS + 1;
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << 47;
    localparam logic [PW-1:0] LIM_POS = (PW'(1) << 47) - PW'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]         r_ansatz;
    logic [2:0]         r_term;
    logic [31:0]        r_step_h;
    logic [9:0]         r_delay;
    logic signed [31:0] r_scale_four;
    logic signed [31:0] r_scale_two;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ansatz     <= wke_pkg::ANSATZ_PLAIN;
            r_term       <= '0;
            r_step_h     <= wke_pkg::RST_STEP_H;
            r_delay      <= '0;
            r_scale_four <= wke_pkg::RST_SCALE_FOUR;
            r_scale_two  <= wke_pkg::RST_SCALE_TWO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                wke_pkg::CFG_ANSATZ_KIND: r_ansatz     <= i_cfg_data[1:0];
                wke_pkg::CFG_TERM_TYPE:   r_term       <= i_cfg_data[2:0];
                wke_pkg::CFG_STEP_H:      r_step_h     <= i_cfg_data;
                wke_pkg::CFG_DELAY_INDEX: r_delay      <= i_cfg_data[9:0];
                wke_pkg::CFG_SCALE_FOUR:  r_scale_four <= i_cfg_data;
                wke_pkg::CFG_SCALE_TWO:   r_scale_two  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless a result is held by the sink
    logic en;
    logic r_out_vld;
    assign en         = !(r_out_vld && i_out_stall);
    assign o_in_stall = !en;

    // Term decode shared by several stages
    logic signed [2:0] term_s;
    logic              term_outer;   // +-2
    logic              term_mid;     // 0
    logic              term_lin_ok;
    logic              term_cst_ok;
    assign term_s      = $signed(r_term);
    assign term_outer  = (term_s == 3'sd2) || (term_s == -3'sd2);
    assign term_mid    = (term_s == 3'sd0);
    assign term_lin_ok = (term_s >= -3'sd2) && (term_s <= 3'sd2);
    assign term_cst_ok = (term_s >= -3'sd1) && (term_s <= 3'sd1);

    // ------------------------------------------------------------------
    // S1: coordinate differences, magnitudes
    // ------------------------------------------------------------------
    logic        r_s1_vld;
    logic [32:0] r_s1_mag [0:2];
    logic signed [32:0] n_df [0:2];
    logic [32:0] n_mag [0:2];

    always_comb begin
        n_df[0] = $signed({i_x_coord_0[31], i_x_coord_0}) - $signed({i_y_coord_0[31], i_y_coord_0});
        n_df[1] = $signed({i_x_coord_1[31], i_x_coord_1}) - $signed({i_y_coord_1[31], i_y_coord_1});
        n_df[2] = $signed({i_x_coord_2[31], i_x_coord_2}) - $signed({i_y_coord_2[31], i_y_coord_2});
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = n_df[k][32] ? 33'(-n_df[k]) : 33'(n_df[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) r_s1_mag[k] <= n_mag[k];
        end
    end

    // ------------------------------------------------------------------
    // S2: squares
    // ------------------------------------------------------------------
    logic        r_s2_vld;
    logic [65:0] r_s2_sq [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) r_s2_sq[k] <= r_s1_mag[k] * r_s1_mag[k];
        end
    end

    // ------------------------------------------------------------------
    // S3 and square root pipeline: element 0 holds the radicand,
    // element k+1 holds the state after root digit k
    // ------------------------------------------------------------------
    logic        r_sr_vld  [0:SQ_N];
    logic [65:0] r_sr_rad  [0:SQ_N];
    logic [34:0] r_sr_rem  [0:SQ_N];
    logic [32:0] r_sr_root [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr_vld[0] <= 1'b0;
        end else if (en) begin
            r_sr_vld[0] <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr_rad[0]  <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_sr_rem[0]  <= '0;
            r_sr_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic [34:0] n_rsh;
        logic [34:0] n_trial;
        logic        n_ge;

        // one radicand bit pair per step
        assign n_rsh   = {r_sr_rem[k][32:0], r_sr_rad[k][65-2*k -: 2]};
        assign n_trial = {r_sr_root[k][32:0], 2'b01};
        assign n_ge    = (n_rsh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sr_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_sr_vld[k+1] <= r_sr_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sr_rad[k+1]  <= r_sr_rad[k];
                r_sr_rem[k+1]  <= n_ge ? (n_rsh - n_trial) : n_rsh;
                r_sr_root[k+1] <= {r_sr_root[k][31:0], n_ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: (dist << FRAC_BITS) / step_h, one quotient bit a stage
    // ------------------------------------------------------------------
    logic          r_dv_vld  [0:DW-1];
    logic [32:0]   r_dv_dist [0:DW-1];
    logic [31:0]   r_dv_rem  [0:DW-1];
    logic [DW-1:0] r_dv_q    [0:DW-1];

    for (genvar k = 0; k < DW; k++) begin : g_div
        localparam int unsigned B = DW - 1 - k;
        logic          p_vld;
        logic [32:0]   p_dist;
        logic [31:0]   p_rem;
        logic [DW-1:0] p_q;
        logic          n_bit;
        logic [32:0]   n_rsh;
        logic          n_ge;
        logic [32:0]   n_diff;
        logic [DW-1:0] n_q;

        if (k == 0) begin : g_first
            assign p_vld  = r_sr_vld[SQ_N];
            assign p_dist = r_sr_root[SQ_N];
            assign p_rem  = '0;
            assign p_q    = '0;
        end else begin : g_next
            assign p_vld  = r_dv_vld[k-1];
            assign p_dist = r_dv_dist[k-1];
            assign p_rem  = r_dv_rem[k-1];
            assign p_q    = r_dv_q[k-1];
        end

        // dividend bits below FRAC_BITS are zero
        if (B >= FRAC_BITS) begin : g_dbit
            assign n_bit = p_dist[B-FRAC_BITS];
        end else begin : g_zbit
            assign n_bit = 1'b0;
        end

        always_comb begin
            n_rsh  = {p_rem, n_bit};
            n_ge   = (n_rsh >= {1'b0, r_step_h});
            n_diff = n_rsh - {1'b0, r_step_h};
            n_q    = p_q;
            n_q[B] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_dist[k] <= p_dist;
                r_dv_rem[k]  <= n_ge ? n_diff[31:0] : n_rsh[31:0];
                r_dv_q[k]    <= n_q;
            end
        end
    end

    // ------------------------------------------------------------------
    // RH: rho = q - (delay << FRAC_BITS), saturated to signed 32 bits
    // ------------------------------------------------------------------
    logic               r_rh_vld;
    logic [32:0]        r_rh_dist;
    logic signed [31:0] r_rh_rho;
    logic               r_rh_clip;
    logic signed [RW-1:0] n_rfull;
    logic               n_rfit;
    logic signed [31:0] n_rho;
    logic               n_rclip;

    always_comb begin
        n_rfull = $signed({1'b0, r_dv_q[DW-1]})
                - $signed(RW'({r_delay, {FRAC_BITS{1'b0}}}));
        n_rfit  = (n_rfull[RW-1:31] == '0) || (n_rfull[RW-1:31] == '1);
        n_rclip = 1'b0;
        n_rho   = n_rfull[31:0];
        if (r_step_h == '0) begin
            n_rho   = 32'sh7FFF_FFFF;
            n_rclip = 1'b1;
        end else if (!n_rfit) begin
            n_rho   = n_rfull[RW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            n_rclip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rh_vld <= 1'b0;
        end else if (en) begin
            r_rh_vld <= r_dv_vld[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rh_dist <= r_dv_dist[DW-1];
            r_rh_rho  <= n_rho;
            r_rh_clip <= n_rclip;
        end
    end

    // ------------------------------------------------------------------
    // SH: shifted rho magnitude, scale multiple, result sign
    // ------------------------------------------------------------------
    logic        r_sh_vld;
    logic [32:0] r_sh_dist;
    logic        r_sh_clip;
    logic [31:0] r_sh_mag;
    logic [33:0] r_sh_ms;
    logic        r_sh_neg;
    logic        r_sh_outer;
    logic signed [33:0] n_toff;
    logic signed [33:0] n_sh;
    logic [33:0] n_shmag;
    logic [31:0] n_s4mag;
    logic [33:0] n_ms;

    always_comb begin
        n_toff  = 34'($signed({term_s, {FRAC_BITS{1'b0}}}));
        n_sh    = 34'(r_rh_rho) - n_toff;
        n_shmag = n_sh[33] ? 34'(-n_sh) : 34'(n_sh);
        n_s4mag = r_scale_four[31] ? 32'(-r_scale_four) : 32'(r_scale_four);
        if (term_outer) begin
            n_ms = {2'b00, n_s4mag};
        end else if (term_mid) begin
            n_ms = {2'b00, n_s4mag} + {1'b0, n_s4mag, 1'b0};
        end else begin
            n_ms = {1'b0, n_s4mag, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_vld <= 1'b0;
        end else if (en) begin
            r_sh_vld <= r_rh_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sh_dist  <= r_rh_dist;
            r_sh_clip  <= r_rh_clip;
            r_sh_mag   <= n_shmag[31:0];
            r_sh_ms    <= n_ms;
            r_sh_neg   <= (term_outer || term_mid) ^ r_scale_four[31];
            r_sh_outer <= term_outer;
        end
    end

    // ------------------------------------------------------------------
    // SQ: square of shifted rho
    // ------------------------------------------------------------------
    logic        r_sq_vld;
    logic [32:0] r_sq_dist;
    logic        r_sq_clip;
    logic [63:0] r_sq_val;
    logic [33:0] r_sq_ms;
    logic        r_sq_neg;
    logic        r_sq_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else if (en) begin
            r_sq_vld <= r_sh_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_dist  <= r_sh_dist;
            r_sq_clip  <= r_sh_clip;
            r_sq_val   <= r_sh_mag * r_sh_mag;
            r_sq_ms    <= r_sh_ms;
            r_sq_neg   <= r_sh_neg;
            r_sq_outer <= r_sh_outer;
        end
    end

    // ------------------------------------------------------------------
    // P1: two 32 x 34 partial products
    // ------------------------------------------------------------------
    logic        r_p1_vld;
    logic [32:0] r_p1_dist;
    logic        r_p1_clip;
    logic [65:0] r_p1_lo;
    logic [65:0] r_p1_hi;
    logic        r_p1_neg;
    logic        r_p1_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_dist  <= r_sq_dist;
            r_p1_clip  <= r_sq_clip;
            r_p1_lo    <= r_sq_val[31:0] * r_sq_ms;
            r_p1_hi    <= r_sq_val[63:32] * r_sq_ms;
            r_p1_neg   <= r_sq_neg;
            r_p1_outer <= r_sq_outer;
        end
    end

    // ------------------------------------------------------------------
    // P2: partial product sum
    // ------------------------------------------------------------------
    logic          r_p2_vld;
    logic [32:0]   r_p2_dist;
    logic          r_p2_clip;
    logic [PW-1:0] r_p2_prod;
    logic          r_p2_neg;
    logic          r_p2_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (en) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_dist  <= r_p1_dist;
            r_p2_clip  <= r_p1_clip;
            r_p2_prod  <= PW'(r_p1_lo) + (PW'(r_p1_hi) << 32);
            r_p2_neg   <= r_p1_neg;
            r_p2_outer <= r_p1_outer;
        end
    end

    // ------------------------------------------------------------------
    // OUT: scale down, saturate, select kernel kind
    // ------------------------------------------------------------------
    logic [32:0]        r_out_dist;
    logic signed [47:0] r_out_num;
    logic               r_out_res;
    logic               r_out_clip;
    logic [PW-1:0]      n_scaled;
    logic               n_sat;
    logic signed [47:0] n_lin;
    logic signed [47:0] n_num;
    logic               n_res;
    logic               n_clip;

    always_comb begin
        n_scaled = r_p2_outer ? (r_p2_prod >> SH_O) : (r_p2_prod >> SH_I);
        if (r_p2_neg) begin
            n_sat = (n_scaled > LIM_NEG);
            n_lin = n_sat ? -48'sh8000_0000_0000 : 48'(-n_scaled[47:0]);
        end else begin
            n_sat = (n_scaled > LIM_POS);
            n_lin = n_sat ? 48'sh7FFF_FFFF_FFFF : $signed(n_scaled[47:0]);
        end

        n_num  = '0;
        n_res  = 1'b0;
        n_clip = 1'b0;
        unique case (r_ansatz)
            wke_pkg::ANSATZ_PLAIN: begin
                n_res = 1'b1;
                n_num = 48'(r_scale_four);
            end
            wke_pkg::ANSATZ_CONST: begin
                if (term_cst_ok) begin
                    n_res = 1'b1;
                    n_num = term_mid ? 48'(r_scale_two) : -48'(r_scale_four);
                end
            end
            wke_pkg::ANSATZ_LINEAR: begin
                if (term_lin_ok) begin
                    n_res  = 1'b1;
                    n_num  = n_lin;
                    n_clip = n_sat || r_p2_clip;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_dist <= r_p2_dist;
            r_out_num  <= n_num;
            r_out_res  <= n_res;
            r_out_clip <= n_clip;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_distance  = r_out_dist;
    assign o_numerator = r_out_num;
    assign o_valid_res = r_out_res;
    assign o_clipped   = r_out_clip;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_vld)
        else $error("accepted transaction did not enter the pipeline");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while the pipeline is frozen");

    a_null_kernel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> (o_numerator == '0 && !o_clipped))
        else $error("null kernel carries a numerator or clip flag");

    a_clip_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |-> (r_ansatz == wke_pkg::ANSATZ_LINEAR))
        else $error("clip flag outside piecewise-linear mode");

endmodule
